// File: src/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
// No dependencies; used by the top level and the cell.
package swm_pkg;

    // Width of the window size register and its value after reset.
    localparam int unsigned CFG_W          = 7;
    localparam int unsigned WINDOW_DEFAULT = 3;

    // Per-transfer control broadcast to every cell.
    typedef struct packed {
        logic load;       // an input transfer updates the chain this cycle
        logic evict;      // window full: the oldest entry leaves
        logic victim_lt;  // the leaving entry sorts before the new sample
    } swm_ctrl_t;

    // Per-cell flags sent back to the top level.
    typedef struct packed {
        logic lt;         // cell valid and its value <= new sample
        logic ev;         // cell holds the oldest entry of a full window
    } swm_stat_t;

endpackage

// File: src/swm_cell.sv
// One cell of the sorted chain: holds a value and its age.
// Depends on swm_pkg; instantiated in a row by sliding_window_median.
module swm_cell #(
    parameter int unsigned DW = 32,
    parameter int unsigned AW = 6
) (
    input  logic                    aclk,
    input  swm_pkg::swm_ctrl_t      ctrl,
    input  logic                    cell_valid,
    input  logic signed [DW-1:0]    new_value,
    input  logic [AW-1:0]           victim_age,
    input  logic                    lt_left,
    input  logic signed [DW-1:0]    left_value,
    input  logic [AW-1:0]           left_age,
    input  logic                    lt_right,
    input  logic signed [DW-1:0]    right_value,
    input  logic [AW-1:0]           right_age,
    input  logic                    ev_le,
    input  logic                    ev_b,
    output swm_pkg::swm_stat_t      stat,
    output logic signed [DW-1:0]    value,
    output logic [AW-1:0]           age,
    output logic signed [DW-1:0]    ins_value
);

    logic signed [DW-1:0] val_reg, val_next;
    logic [AW-1:0]        age_reg, age_next;
    logic                 lt;
    logic signed [DW-1:0] ins_hi_value;
    logic [AW-1:0]        ins_age, ins_hi_age;
    logic                 shift_sel;

    assign lt = cell_valid && (val_reg <= new_value);

    // Entry at this position after the insert.
    always_comb begin
        if (lt) begin
            ins_value = val_reg;
            ins_age   = age_reg + 1'b1;
        end else if (lt_left) begin
            ins_value = new_value;
            ins_age   = '0;
        end else begin
            ins_value = left_value;
            ins_age   = left_age + 1'b1;
        end
    end

    // Entry one position to the right after the insert.
    always_comb begin
        if (lt_right) begin
            ins_hi_value = right_value;
            ins_hi_age   = right_age + 1'b1;
        end else if (lt) begin
            ins_hi_value = new_value;
            ins_hi_age   = '0;
        end else begin
            ins_hi_value = val_reg;
            ins_hi_age   = age_reg + 1'b1;
        end
    end

    // Cells at or past the removed entry close the gap.
    assign shift_sel = ctrl.evict && (ctrl.victim_lt ? ev_le : ev_b);

    always_comb begin
        val_next = val_reg;
        age_next = age_reg;
        if (ctrl.load) begin
            val_next = shift_sel ? ins_hi_value : ins_value;
            age_next = shift_sel ? ins_hi_age   : ins_age;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

    assign stat.lt = lt;
    assign stat.ev = ctrl.evict && cell_valid && (age_reg == victim_age);
    assign value   = val_reg;
    assign age     = age_reg;

endmodule

// File: src/sliding_window_median.sv
// Sliding window median filter: a sorted chain of WINDOW_MAX cells.
// A transfer's median reaches m_* the cycle after; 1 sample per cycle unless m_* stalls.
// Insert, age update and eviction happen in every cell in parallel, in the same cycle.
// Reset (aresetn low, synchronous) empties the window and sets window_size to 3.
// Writing window_size empties the window; results resume once it has refilled.
// Depends on swm_pkg and swm_cell.
module sliding_window_median #(
    parameter int unsigned WINDOW_MAX   = 64,
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: window_size
    input  logic                           cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]      cfg_wdata,
    // sample input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    // median output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_median
);

    localparam int unsigned N  = WINDOW_MAX;
    localparam int unsigned CW = $clog2(N + 1);                 // fill count / window width
    localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;        // age and index width
    localparam int unsigned XW = (CW > swm_pkg::CFG_W) ? CW : swm_pkg::CFG_W;

    // ------------------------------------------------------------------
    // Window size register and fill count
    // ------------------------------------------------------------------
    logic [swm_pkg::CFG_W-1:0] wsize_reg, wsize_next;
    logic [CW-1:0]             fill_reg, fill_next;
    logic [XW-1:0]             ws_x;
    logic [CW-1:0]             ws_eff;
    logic [CW:0]               fill_plus1;
    logic                      full;
    logic                      accept;
    logic                      m_valid_reg, m_valid_next;

    // Zero means a window of one; anything above WINDOW_MAX saturates.
    always_comb begin
        ws_x = XW'(wsize_reg);
        if (ws_x == '0) begin
            ws_x = XW'(1);
        end
        if (ws_x > XW'(N)) begin
            ws_x = XW'(N);
        end
    end
    assign ws_eff = ws_x[CW-1:0];

    // This sample completes the window: emit a median and evict the oldest.
    assign fill_plus1 = {1'b0, fill_reg} + 1'b1;
    assign full       = (fill_plus1 == {1'b0, ws_eff});

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        wsize_next = wsize_reg;
        fill_next  = fill_reg;
        if (cfg_we) begin
            wsize_next = cfg_wdata;
            fill_next  = '0;
        end else if (accept && !full) begin
            fill_next  = fill_plus1[CW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    swm_pkg::swm_ctrl_t            ctrl;
    swm_pkg::swm_stat_t            stat [N];
    logic signed [SAMPLE_WIDTH-1:0] cval [N];
    logic signed [SAMPLE_WIDTH-1:0] cins [N];
    logic [AW-1:0]                 cage [N];
    logic [N-1:0]                  lt_vec, ev_vec, ev_le_vec, ev_b_vec;
    logic [AW-1:0]                 victim_age;
    logic [CW:0]                   ws_m2;

    // Oldest entry has age ws-1 after this transfer, so ws-2 before it.
    assign ws_m2      = {1'b0, ws_eff} - (CW + 1)'(2);
    assign victim_age = ws_m2[AW-1:0];

    assign ctrl.load      = accept;
    assign ctrl.evict     = full && (ws_eff > CW'(1));
    assign ctrl.victim_lt = |(ev_vec & lt_vec);

    for (genvar j = 0; j < N; j++) begin : g_cell
        localparam logic [N-1:0] PREFIX = {N{1'b1}} >> (N - 1 - j);
        logic                           lt_left, lt_right;
        logic signed [SAMPLE_WIDTH-1:0] left_value, right_value;
        logic [AW-1:0]                  left_age, right_age;
        logic                           cell_valid;

        assign lt_vec[j]    = stat[j].lt;
        assign ev_vec[j]    = stat[j].ev;
        // victim at or before this cell / strictly before it
        assign ev_le_vec[j] = |(ev_vec & PREFIX);
        assign ev_b_vec[j]  = ev_le_vec[j] && !ev_vec[j];
        assign cell_valid   = (CW'(j) < fill_reg);

        if (j == 0) begin : g_first
            assign lt_left    = 1'b1;
            assign left_value = s_sample;
            assign left_age   = '0;
        end else begin : g_mid_l
            assign lt_left    = lt_vec[j-1];
            assign left_value = cval[j-1];
            assign left_age   = cage[j-1];
        end

        if (j == N - 1) begin : g_last
            assign lt_right    = 1'b0;
            assign right_value = cval[j];
            assign right_age   = cage[j];
        end else begin : g_mid_r
            assign lt_right    = lt_vec[j+1];
            assign right_value = cval[j+1];
            assign right_age   = cage[j+1];
        end

        swm_cell #(
            .DW (SAMPLE_WIDTH),
            .AW (AW)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .cell_valid  (cell_valid),
            .new_value   (s_sample),
            .victim_age  (victim_age),
            .lt_left     (lt_left),
            .left_value  (left_value),
            .left_age    (left_age),
            .lt_right    (lt_right),
            .right_value (right_value),
            .right_age   (right_age),
            .ev_le       (ev_le_vec[j]),
            .ev_b        (ev_b_vec[j]),
            .stat        (stat[j]),
            .value       (cval[j]),
            .age         (cage[j]),
            .ins_value   (cins[j])
        );
    end

    // ------------------------------------------------------------------
    // Median pick and output register
    // ------------------------------------------------------------------
    logic [CW-1:0]                  mid_pos;
    logic signed [SAMPLE_WIDTH-1:0] median_pick;
    logic signed [SAMPLE_WIDTH-1:0] m_median_reg, m_median_next;

    // Lower median of the window including the new sample, before eviction.
    assign mid_pos     = (ws_eff - 1'b1) >> 1;
    assign median_pick = cins[mid_pos[AW-1:0]];

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_median_next = m_median_reg;
        if (accept && full) begin
            m_valid_next  = 1'b1;
            m_median_next = median_pick;
        end else if (m_ready) begin
            m_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg   <= swm_pkg::CFG_W'(swm_pkg::WINDOW_DEFAULT);
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wsize_reg   <= wsize_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        m_median_reg <= m_median_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_median = m_median_reg;

endmodule

// File: src/swm_checker.sv
// Port-level checks for sliding_window_median, attached by bind.
// Checks handshake, reset and configuration timing; no package dependency.
module swm_checker #(
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_we,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH-1:0] m_median
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_median))
        else $error("median changed or dropped while stalled");

    // Input is stalled only while an untaken result is waiting.
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with output free");

    // No result appears without an input transfer.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) && !(m_valid && !m_ready) |=> !m_valid)
        else $error("result without an input transfer");

    // Reset clears the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Checks that configuration writes come only while no result waits and no input is taken.
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |-> !m_valid && !(s_valid && s_ready))
        else $error("configuration write while a transfer is in flight");

endmodule

bind sliding_window_median swm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_median  (m_median)
);
